>>> rtl/core/set_assoc_cache_tag_engine_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag engine
// Shared property templates, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_ENGINE_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_ENGINE_UNIT_ASSERT_SVH

// Consequent checked in the same cycle
`define SACT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tag engine assertion failed");

// Consequent checked in the next cycle
`define SACT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tag engine assertion failed");

`endif

>>> rtl/core/sact_pkg.sv
// ----------------------------------------------------------------------------
// sact_pkg
// Types, sizes and codes shared by the cache tag engine modules.
// ----------------------------------------------------------------------------
package sact_pkg;

    localparam int SETS       = 256;
    localparam int ROW_W      = 8;
    localparam int WAYS       = 16;
    localparam int WAY_W      = 4;
    localparam int WAYCNT_W   = 5;
    localparam int TAG_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int ADDR_W     = 32;
    localparam int LFSR_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [3:0]        OFF_LIMIT = 4'd12;
    localparam logic [3:0]        IDX_LIMIT = 4'd8;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOC    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED    = 3'd5;

    localparam logic [1:0] POLICY_FIFO = 2'd0;
    localparam logic [1:0] POLICY_LRU  = 2'd1;

    localparam logic CMD_READ = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_SCAN,
        ST_DECIDE,
        ST_MOD,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
    } sact_in_t;

    typedef struct packed {
        logic             hit;
        logic [7:0]       set_index;
        logic [TAG_W-1:0] tag_value;
    } sact_out_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] fill_stamp;
        logic [STAMP_W-1:0] use_stamp;
    } entry_t;

    typedef struct packed {
        logic             rd_valid_en;
        logic             rd_entry_en;
        logic [ROW_W-1:0] rd_row;
        logic [WAY_W-1:0] rd_way;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic [WAY_W-1:0] wr_way;
        entry_t           wr_entry;
        logic [WAYS-1:0]  wr_valid;
    } store_req_t;

endpackage

>>> rtl/core/sact_store.sv
// ----------------------------------------------------------------------------
// sact_store
// Way entry memory (one word per set and way) and per-set valid vector
// memory. A per-set seen flag, cleared at reset, masks stale valid vectors.
// ----------------------------------------------------------------------------
module sact_store (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sact_pkg::store_req_t req,
    output sact_pkg::entry_t     entry_rdata,
    output logic [sact_pkg::WAYS-1:0] valid_rdata
);
    import sact_pkg::*;

    entry_t          entry_mem [SETS*WAYS];
    logic [WAYS-1:0] valid_mem [SETS];
    logic [SETS-1:0] row_seen_reg;
    logic            seen_q_reg;
    logic [WAYS-1:0] valid_q_reg;
    entry_t          entry_q_reg;

    // entry memory, registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            entry_mem[{req.wr_row, req.wr_way}] <= req.wr_entry;
        end
        if (req.rd_entry_en) begin
            entry_q_reg <= entry_mem[{req.rd_row, req.rd_way}];
        end
    end

    // valid vector memory
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            valid_mem[req.wr_row] <= req.wr_valid;
        end
        if (req.rd_valid_en) begin
            valid_q_reg <= valid_mem[req.rd_row];
        end
    end

    // seen flags: a row never written reads as all invalid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_seen_reg <= '0;
            seen_q_reg   <= 1'b0;
        end else begin
            if (req.wr_en) begin
                row_seen_reg[req.wr_row] <= 1'b1;
            end
            if (req.rd_valid_en) begin
                seen_q_reg <= row_seen_reg[req.rd_row];
            end
        end
    end

    assign entry_rdata = entry_q_reg;
    assign valid_rdata = seen_q_reg ? valid_q_reg : '0;

endmodule

>>> rtl/core/sact_mod.sv
// ----------------------------------------------------------------------------
// sact_mod
// Bit-serial remainder of a 16-bit value by the way count, one bit a cycle.
// ----------------------------------------------------------------------------
module sact_mod (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [sact_pkg::LFSR_W-1:0]    dividend,
    input  logic [sact_pkg::WAYCNT_W-1:0]  divisor,
    output logic                           done,
    output logic [sact_pkg::WAY_W-1:0]     rem
);
    import sact_pkg::*;

    logic [WAYCNT_W-1:0] rem_reg;
    logic [LFSR_W-1:0]   dvd_reg;
    logic [WAYCNT_W-1:0] div_reg;
    logic [WAYCNT_W-1:0] cnt_reg;
    logic                run_reg;
    logic                done_reg;
    logic [WAYCNT_W:0]   trial;
    logic [WAYCNT_W:0]   rem_next;

    // restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, dvd_reg[LFSR_W-1]};
        rem_next = (trial >= {1'b0, div_reg}) ? trial - {1'b0, div_reg} : trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                rem_reg <= '0;
                dvd_reg <= dividend;
                div_reg <= divisor;
                cnt_reg <= '0;
            end else if (run_reg) begin
                rem_reg <= rem_next[WAYCNT_W-1:0];
                dvd_reg <= {dvd_reg[LFSR_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == WAYCNT_W'(LFSR_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[WAY_W-1:0];

endmodule

>>> rtl/core/set_assoc_cache_tag_engine_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_engine_unit
// Set-associative tag lookup with FIFO, LRU or random replacement.
//
// Usage:
//   s_valid/s_ready carry one access (command, address). m_valid/m_ready
//   return one result per access: hit, set index and tag, in order.
//   cfg_valid/cfg_ready write the registers by index; write them only while
//   no access is in flight. cfg_ready is always high.
// Timing:
//   One access at a time. The set is scanned one way per cycle out of the
//   entry memory; the access passes ISSUE, SCAN (ended early by a hit) and
//   DECIDE, then MOD when a full set picks a random victim (serial remainder
//   of the LFSR by the way count), then WRITE, which loads the result.
//   s_ready returns as the result is loaded, so the next access waits for it.
// Reset:
//   Registers take their defaults, all ways read invalid, the stamp counter
//   is one. No clearing pass is needed.
// Stall:
//   The result waits in an output register; the next access is accepted and
//   scanned meanwhile, and its result is held until the register frees up.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_engine_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sact_pkg::sact_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sact_pkg::sact_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sact_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sact_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sact_pkg::*;

    state_t state_reg, state_next;

    // configuration
    logic [3:0]          sib_reg, ofb_reg;
    logic [WAYCNT_W-1:0] ways_cfg_reg;
    logic [1:0]          policy_reg;
    logic                walloc_reg;
    logic [LFSR_W-1:0]   lfsr_reg, lfsr_next;

    // per-access context
    logic                cmd_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [WAYCNT_W-1:0] ways_reg;
    logic [WAY_W-1:0]    wcnt_reg;
    logic                hit_reg;
    logic [WAY_W-1:0]    hit_way_reg;
    logic [STAMP_W-1:0]  hit_fill_reg;
    logic                inv_found_reg;
    logic [WAY_W-1:0]    inv_way_reg;
    logic [WAY_W-1:0]    minf_way_reg, minu_way_reg;
    logic [STAMP_W-1:0]  minf_val_reg, minu_val_reg;
    logic [WAY_W-1:0]    victim_reg;
    logic                alloc_reg;
    logic [STAMP_W-1:0]  counter_reg;
    sact_out_t           out_reg;
    logic                out_valid_reg;

    // address split
    logic [3:0]          ob, ib;
    logic [ADDR_W-1:0]   set_full;
    logic [8:0]          set_mask;
    logic [7:0]          set_sel;
    logic [TAG_W-1:0]    tag_sel;
    logic [WAYCNT_W-1:0] ways_clamped;

    // scan and store
    store_req_t          sreq;
    entry_t              entry_rdata;
    logic [WAYS-1:0]     valid_rdata;
    logic                way_valid, way_match, scan_last;
    logic                go;
    logic                rand_start, mod_done;
    logic [WAY_W-1:0]    mod_rem;
    logic [WAYS-1:0]     victim_onehot;

    always_comb begin
        ob           = (ofb_reg > OFF_LIMIT) ? OFF_LIMIT : ofb_reg;
        ib           = (sib_reg > IDX_LIMIT) ? IDX_LIMIT : sib_reg;
        set_full     = s_data.address >> ob;
        set_mask     = (9'd1 << ib) - 9'd1;
        set_sel      = set_full[7:0] & set_mask[7:0];
        tag_sel      = s_data.address >> ({1'b0, ob} + {1'b0, ib});
        ways_clamped = (ways_cfg_reg == '0) ? WAYCNT_W'(1) :
                       (ways_cfg_reg > WAYCNT_W'(WAYS)) ? WAYCNT_W'(WAYS) : ways_cfg_reg;
    end

    // way under scan
    always_comb begin
        way_valid = valid_rdata[wcnt_reg];
        way_match = way_valid && (entry_rdata.tag == tag_reg);
        scan_last = ({1'b0, wcnt_reg} == ways_reg - 1'b1);
        go        = !out_valid_reg || m_ready;
        lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
        rand_start = (state_reg == ST_DECIDE) && !hit_reg && !inv_found_reg &&
                     (cmd_reg == CMD_READ || walloc_reg) &&
                     policy_reg != POLICY_FIFO && policy_reg != POLICY_LRU;
        victim_onehot = WAYS'(1) << victim_reg;
    end

    // memory requests
    always_comb begin
        sreq.rd_valid_en         = (state_reg == ST_ISSUE);
        sreq.rd_entry_en         = (state_reg == ST_ISSUE) || (state_reg == ST_SCAN);
        sreq.rd_row              = row_reg;
        sreq.rd_way              = (state_reg == ST_ISSUE) ? '0 : wcnt_reg + 1'b1;
        sreq.wr_en               = (state_reg == ST_WRITE) && go && alloc_reg;
        sreq.wr_row              = row_reg;
        sreq.wr_way              = victim_reg;
        sreq.wr_entry.tag        = tag_reg;
        sreq.wr_entry.fill_stamp = hit_reg ? hit_fill_reg : counter_reg;
        sreq.wr_entry.use_stamp  = counter_reg;
        sreq.wr_valid            = valid_rdata | victim_onehot;
    end

    sact_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (sreq),
        .entry_rdata (entry_rdata),
        .valid_rdata (valid_rdata)
    );

    sact_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rand_start),
        .dividend (lfsr_next),
        .divisor  (ways_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_ISSUE;
            end
            ST_ISSUE: state_next = ST_SCAN;
            ST_SCAN: begin
                if (way_match || scan_last) state_next = ST_DECIDE;
            end
            ST_DECIDE: state_next = rand_start ? ST_MOD : ST_WRITE;
            ST_MOD: begin
                if (mod_done) state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (go) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // configuration, LFSR and stamp counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sib_reg      <= 4'd0;
            ofb_reg      <= 4'd6;
            ways_cfg_reg <= WAYCNT_W'(4);
            policy_reg   <= POLICY_LRU;
            walloc_reg   <= 1'b1;
            lfsr_reg     <= LFSR_W'(1);
            counter_reg  <= STAMP_W'(1);
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SET_INDEX_BITS: sib_reg      <= cfg_data[3:0];
                    CFG_OFFSET_BITS:    ofb_reg      <= cfg_data[3:0];
                    CFG_WAYS_IN_USE:    ways_cfg_reg <= cfg_data[WAYCNT_W-1:0];
                    CFG_POLICY:         policy_reg   <= cfg_data[1:0];
                    CFG_WRITE_ALLOC:    walloc_reg   <= cfg_data[0];
                    CFG_RANDOM_SEED: begin
                        lfsr_reg <= (cfg_data == '0) ? LFSR_W'(1) : cfg_data;
                    end
                    default: ;
                endcase
            end
            if (rand_start) lfsr_reg <= lfsr_next;
            if (state_reg == ST_WRITE && go && counter_reg != '1) begin
                counter_reg <= counter_reg + 1'b1;
            end
        end
    end

    // access context and scan results
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cmd_reg  <= s_data.command;
                row_reg  <= set_sel;
                tag_reg  <= tag_sel;
                ways_reg <= ways_clamped;
            end
            ST_ISSUE: begin
                wcnt_reg      <= '0;
                hit_reg       <= 1'b0;
                inv_found_reg <= 1'b0;
            end
            ST_SCAN: begin
                wcnt_reg <= wcnt_reg + 1'b1;
                if (way_match) begin
                    hit_reg      <= 1'b1;
                    hit_way_reg  <= wcnt_reg;
                    hit_fill_reg <= entry_rdata.fill_stamp;
                end
                if (!way_valid && !inv_found_reg) begin
                    inv_found_reg <= 1'b1;
                    inv_way_reg   <= wcnt_reg;
                end
                // strict compare keeps the lowest way on ties
                if (wcnt_reg == '0 || entry_rdata.fill_stamp < minf_val_reg) begin
                    minf_val_reg <= entry_rdata.fill_stamp;
                    minf_way_reg <= wcnt_reg;
                end
                if (wcnt_reg == '0 || entry_rdata.use_stamp < minu_val_reg) begin
                    minu_val_reg <= entry_rdata.use_stamp;
                    minu_way_reg <= wcnt_reg;
                end
            end
            ST_DECIDE: begin
                alloc_reg <= hit_reg || cmd_reg == CMD_READ || walloc_reg;
                if (hit_reg)                     victim_reg <= hit_way_reg;
                else if (inv_found_reg)          victim_reg <= inv_way_reg;
                else if (policy_reg == POLICY_FIFO) victim_reg <= minf_way_reg;
                else if (policy_reg == POLICY_LRU)  victim_reg <= minu_way_reg;
            end
            ST_MOD: begin
                if (mod_done) victim_reg <= mod_rem;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == ST_WRITE && go) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE && go) begin
            out_reg.hit       <= hit_reg;
            out_reg.set_index <= row_reg;
            out_reg.tag_value <= tag_reg;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

endmodule

>>> rtl/core/sact_checker.sv
// ----------------------------------------------------------------------------
// sact_checker
// Port-level checks on the tag engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tag_engine_unit_assert.svh"

module sact_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sact_pkg::sact_out_t m_data
);

    // a stalled result holds
    `SACT_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // one access in flight: no accept right after an accept
    `SACT_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)

    // a result never appears the cycle after its access is taken
    `SACT_ASSERT_NEXT(a_no_instant_result, s_valid && s_ready && !m_valid, !m_valid)

endmodule

bind set_assoc_cache_tag_engine_unit sact_checker u_sact_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Randomized check of the cache tag engine: accesses go in over a handshake
// and every result is compared against a cycle-free model of the tag, valid
// and stamp store, through FIFO, LRU and random replacement settings.
// ----------------------------------------------------------------------------
module tb_top;
    import sact_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sact_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sact_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always #6 aclk = ~aclk;

    set_assoc_cache_tag_engine_unit dut (.*);

    // cache model state
    logic [TAG_W-1:0] mdl_tag [SETS][WAYS];
    logic mdl_valid [SETS][WAYS];
    logic [STAMP_W-1:0] mdl_fill [SETS][WAYS];
    logic [STAMP_W-1:0] mdl_use [SETS][WAYS];
    logic [STAMP_W-1:0] mdl_clock;
    logic [LFSR_W-1:0] mdl_lfsr;
    logic [3:0] r_index_bits, r_offset_bits;
    logic [4:0] r_ways;
    logic [1:0] r_policy;
    logic r_walloc;

    sact_in_t access_q[$];
    sact_out_t lookup_q[$];
    int n_bad = 0;
    int cycle = 0;
    int recv_hold = 0;
    logic sender_pause = 1'b0;

    function automatic void model_reset();
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS; w++) begin
                mdl_valid[s][w] = 1'b0;
                mdl_tag[s][w] = '0;
                mdl_fill[s][w] = '0;
                mdl_use[s][w] = '0;
            end
        mdl_clock = 1;
        r_index_bits = 0; r_offset_bits = 6; r_ways = 4; r_policy = 1; r_walloc = 1;
        mdl_lfsr = 1;
    endfunction

    function automatic void model_write_reg(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_SET_INDEX_BITS: r_index_bits = val[3:0];
            CFG_OFFSET_BITS:    r_offset_bits = val[3:0];
            CFG_WAYS_IN_USE:    r_ways = val[4:0];
            CFG_POLICY:         r_policy = val[1:0];
            CFG_WRITE_ALLOC:    r_walloc = val[0];
            CFG_RANDOM_SEED:    mdl_lfsr = (val == 0) ? 16'd1 : val;
            default: ;
        endcase
    endfunction

    // predicted result of one access, updating the model store
    function automatic sact_out_t lookup_access(sact_in_t acc);
        sact_out_t res;
        int ob, ib, nw, row, victim, hw;
        logic [31:0] set_no, tag;
        logic hit, found;
        ob = (r_offset_bits > OFF_LIMIT) ? OFF_LIMIT : r_offset_bits;
        ib = (r_index_bits > IDX_LIMIT) ? IDX_LIMIT : r_index_bits;
        nw = (r_ways == 0) ? 1 : (r_ways > WAYS) ? WAYS : r_ways;
        set_no = (acc.address >> ob) & ((32'd1 << ib) - 1);
        tag = acc.address >> (ob + ib);
        row = set_no % SETS;
        hit = 1'b0; hw = 0;
        for (int w = 0; w < nw; w++)
            if (!hit && mdl_valid[row][w] && mdl_tag[row][w] == tag) begin
                hit = 1'b1; hw = w;
            end
        if (hit) begin
            mdl_use[row][hw] = mdl_clock;
        end else if (acc.command == CMD_READ || r_walloc) begin
            found = 1'b0; victim = 0;
            for (int w = 0; w < nw; w++)
                if (!found && !mdl_valid[row][w]) begin
                    victim = w; found = 1'b1;
                end
            if (!found) begin
                if (r_policy == POLICY_FIFO || r_policy == POLICY_LRU) begin
                    for (int w = 1; w < nw; w++)
                        if (r_policy == POLICY_FIFO ? mdl_fill[row][w] < mdl_fill[row][victim]
                                                    : mdl_use[row][w] < mdl_use[row][victim])
                            victim = w;
                end else begin
                    mdl_lfsr = mdl_lfsr[0] ? ((mdl_lfsr >> 1) ^ LFSR_TAPS) : (mdl_lfsr >> 1);
                    victim = mdl_lfsr % nw;
                end
            end
            mdl_tag[row][victim] = tag;
            mdl_valid[row][victim] = 1'b1;
            mdl_fill[row][victim] = mdl_clock;
            mdl_use[row][victim] = mdl_clock;
        end
        if (mdl_clock != '1) mdl_clock++;
        res.hit = hit;
        res.set_index = set_no[7:0];
        res.tag_value = tag;
        return res;
    endfunction

    // access driver: bursts with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                lookup_q = {lookup_q, lookup_access(s_data)};
                void'(access_q.pop_front());
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (access_q.size() > 0 && !sender_pause) begin
                    s_valid <= 1'b1;
                    s_data <= access_q[0];
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver with its own stall pattern
    always @(posedge aclk) begin
        if (aresetn) begin
            if (recv_hold > 0) begin
                m_ready <= 1'b0;
                recv_hold <= recv_hold - 1;
            end else begin
                case ($urandom_range(0, 3))
                    0: m_ready <= 1'b0;
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (lookup_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result %p", m_data);
            end else begin
                sact_out_t exp_res;
                exp_res = lookup_q.pop_front();
                if (m_data.hit !== exp_res.hit || m_data.set_index !== exp_res.set_index
                    || m_data.tag_value !== exp_res.tag_value) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: expected %p, got %p", exp_res, m_data);
                end
            end
        end
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (cycle > 900000) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic wait_drained();
        while (access_q.size() != 0 || s_valid || lookup_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        model_write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic sact_in_t make_access(logic cmd, logic [31:0] addr);
        sact_in_t a;
        a.command = cmd;
        a.address = addr;
        return a;
    endfunction

    // append one access to the pending queue
    task automatic enqueue(logic cmd, logic [31:0] addr);
        access_q = {access_q, make_access(cmd, addr)};
    endtask

    // random accesses drawn from a small tag pool so sets fill and evict
    task automatic queue_random(int count);
        logic [31:0] pool [8];
        for (int i = 0; i < 8; i++) pool[i] = $urandom;
        for (int i = 0; i < count; i++) begin
            logic [31:0] a;
            if ($urandom_range(0, 9) == 0) a = $urandom;
            else a = pool[$urandom_range(0, 7)] ^ ($urandom_range(0, 15) << $urandom_range(0, 20));
            enqueue(1'($urandom_range(0, 1)), a);
        end
    endtask

    initial begin
        model_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: default settings, extremes and a full-set eviction
        enqueue(1'b0, 32'h0000_0000);
        enqueue(1'b0, 32'h0000_0000);
        enqueue(1'b1, 32'hFFFF_FFFF);
        enqueue(1'b1, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++)
            enqueue(1'b0, 32'(i << 6));
        enqueue(1'b0, 32'h0000_0040);
        wait_drained();

        // write-through no-allocate: write miss leaves the set alone, write hit refreshes
        write_reg(CFG_WRITE_ALLOC, 16'd0);
        enqueue(1'b1, 32'h1234_5678);
        enqueue(1'b0, 32'h1234_5678);
        enqueue(1'b1, 32'h1234_5678);
        enqueue(1'b1, 32'h8765_4321);
        wait_drained();

        // oversized fields, zero ways, unused policy code, zero seed
        write_reg(CFG_SET_INDEX_BITS, 16'd15);
        write_reg(CFG_OFFSET_BITS, 16'd15);
        write_reg(CFG_WAYS_IN_USE, 16'd0);
        write_reg(CFG_POLICY, 16'd3);
        write_reg(CFG_RANDOM_SEED, 16'd0);
        write_reg(CFG_WRITE_ALLOC, 16'd1);
        enqueue(1'b0, 32'hFFFF_F000);
        enqueue(1'b0, 32'h0000_0FFF);
        enqueue(1'b0, 32'hAAAA_A555);
        wait_drained();
        write_reg(CFG_WAYS_IN_USE, 16'd31);
        enqueue(1'b1, 32'h5555_5AAA);
        wait_drained();

        // random phases across settings
        for (int ph = 0; ph < 14; ph++) begin
            write_reg(CFG_SET_INDEX_BITS,
                      CFG_DATA_W'((ph == 0) ? 0 : (ph == 1) ? 8 : $urandom_range(0, 15)));
            write_reg(CFG_OFFSET_BITS,
                      CFG_DATA_W'((ph == 0) ? 0 : (ph == 1) ? 12 : $urandom_range(0, 15)));
            write_reg(CFG_WAYS_IN_USE,
                      CFG_DATA_W'((ph == 2) ? 1 : (ph == 3) ? 16 : $urandom_range(0, 31)));
            write_reg(CFG_POLICY, CFG_DATA_W'(ph % 4));
            write_reg(CFG_WRITE_ALLOC, CFG_DATA_W'($urandom_range(0, 1)));
            write_reg(CFG_RANDOM_SEED,
                      CFG_DATA_W'((ph == 4) ? 16'hFFFF : $urandom_range(0, 65535)));
            if (ph == 5) recv_hold = 300;
            queue_random(124);
            if (ph == 7) begin
                while (access_q.size() > 60) @(posedge aclk);
                sender_pause = 1'b1;
                while (lookup_q.size() != 0 || s_valid) @(posedge aclk);
                sender_pause = 1'b0;
            end
            wait_drained();
        end

        if (n_bad == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
